FILE: design/assert_macros.svh
// Assertion macros, included by rect_fill_2bpp_unit.sv.
// RFILL_ASSERT checks while out of reset; RFILL_ASSERT_NR checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RFILL_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define RFILL_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFILL_ASSERT(name, clk, rstn, prop, msg)
`define RFILL_ASSERT_NR(name, clk, prop, msg)
`endif

`endif

FILE: design/rfill_pkg.sv
package rfill_pkg;

  // Frame store geometry
  localparam int ROW_BYTES = 40;
  localparam int ROWS      = 128;
  localparam int COLS      = 4 * ROW_BYTES;
  localparam int DEPTH     = ROW_BYTES * ROWS;
  localparam int ADDR_W    = $clog2(DEPTH);
  // Byte column index of an 8-bit pixel column
  localparam int BYTE_W    = 6;

  // Pixels lo..3 of a byte, pixel 0 in bits 7:6
  localparam logic [7:0] LEFT_MASK [4] = '{8'hff, 8'h3f, 8'h0f, 8'h03};
  // Pixels 0..hi of a byte
  localparam logic [7:0] RIGHT_MASK [4] = '{8'hc0, 8'hf0, 8'hfc, 8'hff};

  // Request kinds carried on in_tuser
  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_DONE
  } rfill_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] pattern;
  } rfill_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } rfill_res_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } rfill_mem_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
  } rfill_stat_t;

endpackage

FILE: design/rect_fill_2bpp_unit.sv
// Read word: setup, read address, read data, done (a read off the store skips to done).
// Fill word: setup, a read and a write state per covered byte per covered row, then done
// (a fill that paints nothing skips to done); done waits for the output register,
// then the next word is accepted. Each byte is a read then a write-back on the single
// frame-store port. Reset (rst_n low, synchronous) zeroes the 5120-byte store in a
// clearing pass; in_tready stays low until the pass ends.
`include "assert_macros.svh"

module rect_fill_2bpp_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // x, y, width, height, pattern
  input  logic [0:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_data
  output logic [0:0]  out_tuser   // clipped
);

  rfill_pkg::rfill_req_t     req;
  rfill_pkg::rfill_res_t     res;
  rfill_pkg::rfill_stat_t    stat;
  rfill_pkg::rfill_mem_cmd_t mem_cmd;
  logic [7:0]                mem_rdata;
  logic                      res_ready;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [7:0]                out_data_r, out_data_nxt;
  logic                      out_clip_r, out_clip_nxt;

  // Unpack the input word
  always_comb begin
    req.req_type = in_tuser[0];
    req.x        = in_tdata[7:0];
    req.y        = in_tdata[15:8];
    req.width    = in_tdata[23:16];
    req.height   = in_tdata[31:24];
    req.pattern  = in_tdata[39:32];
  end

  assign in_tready = stat.ready;
  assign res_ready = !out_tvalid_r || out_tready;

  rfill_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid),
    .req       (req),
    .res_ready (res_ready),
    .mem_rdata (mem_rdata),
    .mem_cmd   (mem_cmd),
    .stat      (stat),
    .res       (res)
  );

  rfill_mem u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    out_clip_nxt   = out_clip_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (stat.done && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = res.read_data;
      out_clip_nxt   = res.clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_clip_r;

  `RFILL_ASSERT(a_one_word_in_flight, clk, rst_n,
                (in_tvalid && in_tready) |=> !in_tready, "input accepted twice in a row")
  `RFILL_ASSERT(a_result_from_done, clk, rst_n,
                $rose(out_tvalid_r) |-> $past(stat.done), "result loaded without a finished word")
  `RFILL_ASSERT(a_no_write_when_ready, clk, rst_n,
                mem_cmd.we |-> !in_tready, "store written while taking input")
  `RFILL_ASSERT_NR(a_reset_clears_out, clk,
                   !rst_n |=> !out_tvalid_r, "output valid survived reset")

endmodule

FILE: design/rfill_mem.sv
module rfill_mem (
  input  logic                   clk,
  input  rfill_pkg::rfill_mem_cmd_t cmd,
  output logic [7:0]             rdata
);

  logic [7:0] mem [rfill_pkg::DEPTH];

  // Single port: write, or registered read
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata <= mem[cmd.addr];
    end
  end

endmodule

FILE: design/rfill_seq.sv
module rfill_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  rfill_pkg::rfill_req_t     req,
  input  logic                      res_ready,
  input  logic [7:0]                mem_rdata,
  output rfill_pkg::rfill_mem_cmd_t mem_cmd,
  output rfill_pkg::rfill_stat_t    stat,
  output rfill_pkg::rfill_res_t     res
);

  localparam int AW = rfill_pkg::ADDR_W;
  localparam int BW = rfill_pkg::BYTE_W;

  rfill_pkg::rfill_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  rfill_pkg::rfill_req_t req_r, req_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  logic [BW-1:0]         byte_r, byte_nxt;
  logic [BW-1:0]         first_byte_r, first_byte_nxt;
  logic [BW-1:0]         last_byte_r, last_byte_nxt;
  logic [7:0]            row_r, row_nxt;
  logic [7:0]            last_row_r, last_row_nxt;
  logic [7:0]            lmask_r, lmask_nxt;
  logic [7:0]            rmask_r, rmask_nxt;
  logic                  clip_r, clip_nxt;
  logic [7:0]            data_r, data_nxt;

  // Bounds of the request, used in the setup cycle
  logic [8:0] x9, y9, xe_sum, ye_sum, xe_c, ye_c, xe_m1, ye_m1;
  logic       nz, run;
  logic [7:0] merge_mask;

  always_comb begin
    x9     = {1'b0, req_r.x};
    y9     = {1'b0, req_r.y};
    xe_sum = x9 + {1'b0, req_r.width};
    ye_sum = y9 + {1'b0, req_r.height};
    xe_c   = (xe_sum > 9'(rfill_pkg::COLS)) ? 9'(rfill_pkg::COLS) : xe_sum;
    ye_c   = (ye_sum > 9'(rfill_pkg::ROWS)) ? 9'(rfill_pkg::ROWS) : ye_sum;
    xe_m1  = xe_c - 9'd1;
    ye_m1  = ye_c - 9'd1;
    nz     = (req_r.width != 8'd0) && (req_r.height != 8'd0);
    run    = nz && (x9 < xe_c) && (y9 < ye_c);
  end

  // Pixels of the current byte covered by the rectangle
  always_comb begin
    merge_mask = 8'hff;
    if (byte_r == first_byte_r) begin
      merge_mask = merge_mask & lmask_r;
    end
    if (byte_r == last_byte_r) begin
      merge_mask = merge_mask & rmask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfill_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    base_r       <= base_nxt;
    byte_r       <= byte_nxt;
    first_byte_r <= first_byte_nxt;
    last_byte_r  <= last_byte_nxt;
    row_r        <= row_nxt;
    last_row_r   <= last_row_nxt;
    lmask_r      <= lmask_nxt;
    rmask_r      <= rmask_nxt;
    clip_r       <= clip_nxt;
    data_r       <= data_nxt;
  end

  // Next state, memory commands and walk counters
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    req_nxt        = req_r;
    base_nxt       = base_r;
    byte_nxt       = byte_r;
    first_byte_nxt = first_byte_r;
    last_byte_nxt  = last_byte_r;
    row_nxt        = row_r;
    last_row_nxt   = last_row_r;
    lmask_nxt      = lmask_r;
    rmask_nxt      = rmask_r;
    clip_nxt       = clip_r;
    data_nxt       = data_r;
    mem_cmd        = '0;
    stat           = '0;

    unique case (state_r)
      rfill_pkg::ST_CLEAR: begin
        // Zero one byte per cycle after reset
        mem_cmd.we   = 1'b1;
        mem_cmd.addr = clr_r;
        clr_nxt      = clr_r + AW'(1);
        if (clr_r == AW'(rfill_pkg::DEPTH - 1)) begin
          state_nxt = rfill_pkg::ST_IDLE;
        end
      end
      rfill_pkg::ST_IDLE: begin
        stat.ready = 1'b1;
        if (start) begin
          req_nxt   = req;
          state_nxt = rfill_pkg::ST_SETUP;
        end
      end
      rfill_pkg::ST_SETUP: begin
        base_nxt       = AW'(req_r.y) * AW'(rfill_pkg::ROW_BYTES);
        byte_nxt       = req_r.x[7:2];
        first_byte_nxt = req_r.x[7:2];
        last_byte_nxt  = xe_m1[7:2];
        row_nxt        = req_r.y;
        last_row_nxt   = ye_m1[7:0];
        lmask_nxt      = rfill_pkg::LEFT_MASK[req_r.x[1:0]];
        rmask_nxt      = rfill_pkg::RIGHT_MASK[xe_m1[1:0]];
        data_nxt       = 8'd0;
        if (req_r.req_type == rfill_pkg::REQ_READ) begin
          clip_nxt  = !((x9 < 9'(rfill_pkg::COLS)) && (y9 < 9'(rfill_pkg::ROWS)));
          state_nxt = clip_nxt ? rfill_pkg::ST_DONE : rfill_pkg::ST_RD_ADDR;
        end else begin
          clip_nxt  = nz && ((xe_sum > 9'(rfill_pkg::COLS)) ||
                             (ye_sum > 9'(rfill_pkg::ROWS)));
          state_nxt = run ? rfill_pkg::ST_FILL_RD : rfill_pkg::ST_DONE;
        end
      end
      rfill_pkg::ST_RD_ADDR: begin
        mem_cmd.re   = 1'b1;
        mem_cmd.addr = base_r + AW'(req_r.x[7:2]);
        state_nxt    = rfill_pkg::ST_RD_DATA;
      end
      rfill_pkg::ST_RD_DATA: begin
        data_nxt  = mem_rdata;
        state_nxt = rfill_pkg::ST_DONE;
      end
      rfill_pkg::ST_FILL_RD: begin
        mem_cmd.re   = 1'b1;
        mem_cmd.addr = base_r + AW'(byte_r);
        state_nxt    = rfill_pkg::ST_FILL_WR;
      end
      rfill_pkg::ST_FILL_WR: begin
        // Merge the pattern under the mask and write back
        mem_cmd.we    = 1'b1;
        mem_cmd.addr  = base_r + AW'(byte_r);
        mem_cmd.wdata = (mem_rdata & ~merge_mask) | (req_r.pattern & merge_mask);
        state_nxt     = rfill_pkg::ST_FILL_RD;
        if (byte_r == last_byte_r) begin
          byte_nxt = first_byte_r;
          row_nxt  = row_r + 8'd1;
          base_nxt = base_r + AW'(rfill_pkg::ROW_BYTES);
          if (row_r == last_row_r) begin
            state_nxt = rfill_pkg::ST_DONE;
          end
        end else begin
          byte_nxt = byte_r + BW'(1);
        end
      end
      rfill_pkg::ST_DONE: begin
        stat.done = 1'b1;
        if (res_ready) begin
          state_nxt = rfill_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rfill_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.read_data = data_r;
  assign res.clipped   = clip_r;

endmodule

FILE: verif/tb_rect_fill_2bpp_unit.sv
`timescale 1ns / 1ps

module tb_rect_fill_2bpp_unit;
  import rfill_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int HOLDOFF_AT    = 400;
  localparam int HOLDOFF_CYC   = 300;
  localparam int DRAIN_AT      = 800;
  localparam int DRAIN_CYCLES  = 16;

  // One directed word: the request, and a typed-in result where it is obvious
  typedef struct packed {
    rfill_req_t req;
    logic       typed;
    rfill_res_t res;
  } directed_row_t;

  localparam int N_DIRECTED = 25;
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // cleared store, then reads off the right and bottom edges
    '{'{REQ_READ, 8'd0,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd159, 8'd127, 8'd0,   8'd0,   8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd160, 8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{REQ_READ, 8'd0,   8'd128, 8'd0,   8'd0,   8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{REQ_READ, 8'd255, 8'd255, 8'hff,  8'hff,  8'hff}, 1'b1, '{8'h00, 1'b1}},
    // empty fills
    '{'{REQ_FILL, 8'd4,   8'd4,   8'd0,   8'd5,   8'hff}, 1'b1, '{8'h00, 1'b0}},
    '{'{REQ_FILL, 8'd4,   8'd4,   8'd5,   8'd0,   8'hff}, 1'b1, '{8'h00, 1'b0}},
    // whole store, clipped on both edges
    '{'{REQ_FILL, 8'd0,   8'd0,   8'd255, 8'd255, 8'hff}, 1'b1, '{8'h00, 1'b1}},
    '{'{REQ_READ, 8'd0,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{8'hff, 1'b0}},
    '{'{REQ_READ, 8'd159, 8'd127, 8'd0,   8'd0,   8'h00}, 1'b1, '{8'hff, 1'b0}},
    // span inside one byte
    '{'{REQ_FILL, 8'd1,   8'd2,   8'd2,   8'd1,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd0,   8'd2,   8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    // span across byte boundaries
    '{'{REQ_FILL, 8'd3,   8'd3,   8'd6,   8'd2,   8'h55}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd3,   8'd3,   8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd4,   8'd4,   8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd8,   8'd3,   8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    // past the right edge, no wrap into the next row
    '{'{REQ_FILL, 8'd150, 8'd10,  8'd20,  8'd1,   8'haa}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd159, 8'd10,  8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd0,   8'd11,  8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    // start beyond the right edge paints nothing
    '{'{REQ_FILL, 8'd200, 8'd0,   8'd10,  8'd1,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    // past the bottom, no wrap to row 0
    '{'{REQ_FILL, 8'd0,   8'd120, 8'd4,   8'd20,  8'h1b}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd0,   8'd127, 8'd0,   8'd0,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_FILL, 8'd159, 8'd127, 8'd1,   8'd1,   8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'd159, 8'd127, 8'hff,  8'hff,  8'hff}, 1'b0, '{8'h00, 1'b0}},
    // start below the bottom paints nothing
    '{'{REQ_FILL, 8'd0,   8'd200, 8'd8,   8'd4,   8'h00}, 1'b0, '{8'h00, 1'b0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // x, y, width, height, pattern
  logic [0:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_data
  logic [0:0]  out_tuser;  // clipped

  // Shadow frame store and results still owed by the block
  logic [7:0]  frame_model [DEPTH];
  rfill_res_t  pending_results [$];

  int errors;
  int words_sent;
  int fills_sent;
  int reads_sent;
  int results_seen;
  int clipped_seen;

  rect_fill_2bpp_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow store and return the result it gives
  function automatic rfill_res_t paint_or_read(rfill_req_t r);
    rfill_res_t res;
    int         x_end;
    int         y_end;
    int         row;
    int         col_byte;
    int         lo;
    int         hi;
    int         idx;
    logic [7:0] m;
    res = '0;
    if (r.req_type == REQ_READ) begin
      if (int'(r.x) < COLS && int'(r.y) < ROWS) begin
        res.read_data = frame_model[int'(r.y) * ROW_BYTES + int'(r.x) / 4];
      end else begin
        res.clipped = 1'b1;
      end
    end else if (r.width != 8'd0 && r.height != 8'd0) begin
      x_end = int'(r.x) + int'(r.width);
      y_end = int'(r.y) + int'(r.height);
      if (x_end > COLS) begin
        x_end = COLS;
        res.clipped = 1'b1;
      end
      if (y_end > ROWS) begin
        y_end = ROWS;
        res.clipped = 1'b1;
      end
      if (int'(r.x) < x_end) begin
        for (row = int'(r.y); row < y_end; row++) begin
          for (col_byte = int'(r.x) / 4; col_byte <= (x_end - 1) / 4; col_byte++) begin
            lo = (int'(r.x) > 4 * col_byte) ? int'(r.x) - 4 * col_byte : 0;
            hi = (x_end < 4 * col_byte + 4) ? x_end - 4 * col_byte : 4;
            // pixel p sits in bits 7-2p and 6-2p
            m = 8'h00;
            for (int p = lo; p < hi; p++) m[7 - 2 * p -: 2] = 2'b11;
            idx = row * ROW_BYTES + col_byte;
            frame_model[idx] = (frame_model[idx] & ~m) | (r.pattern & m);
          end
        end
      end
    end
    return res;
  endfunction

  // Offer one word after a gap (none for 20 words in each 100, else random) and hold it until accepted
  task automatic send_word(rfill_req_t r, logic typed, rfill_res_t typed_res);
    int         gap;
    rfill_res_t predicted;
    gap = (words_sent % 100 < 20) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.pattern, r.height, r.width, r.y, r.x};
    in_tuser  <= r.req_type;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = paint_or_read(r);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    if (r.req_type == REQ_READ) reads_sent++;
    else fills_sent++;
  endtask

  // Receiver: random stalls, one long hold-off, compare each result word
  initial begin
    int         stall;
    rfill_res_t exp_res;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (results_seen == HOLDOFF_AT) stall = HOLDOFF_CYC;
      else if (results_seen % 100 >= 50 && results_seen % 100 < 70) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      if (out_tuser[0]) clipped_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: read_data %02h clipped %b", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata !== exp_res.read_data) begin
          $error("read_data mismatch: expected %02h, actual %02h",
                 exp_res.read_data, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== exp_res.clipped) begin
          $error("clipped mismatch: expected %b, actual %b", exp_res.clipped, out_tuser);
          errors++;
        end
      end
    end
  end

  // Reset, directed rows, random words, drain, verdict
  initial begin
    rfill_req_t r;
    int         kind;
    errors       = 0;
    words_sent   = 0;
    fills_sent   = 0;
    reads_sent   = 0;
    results_seen = 0;
    clipped_seen = 0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = REQ_FILL;
    rst_n        = 1'b0;
    foreach (frame_model[i]) frame_model[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // hold the input until the block has emptied out once
      if (i == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 99);
      r.pattern = 8'($urandom);
      if (i % 150 == 75) begin
        // rare large fill, any size
        r.req_type = REQ_FILL;
        r.x        = 8'($urandom_range(0, 255));
        r.y        = 8'($urandom_range(0, 255));
        r.width    = 8'($urandom_range(0, 255));
        r.height   = 8'($urandom_range(0, 255));
      end else if (kind < 50) begin
        // small fill near or inside the store
        r.req_type = REQ_FILL;
        r.x        = 8'($urandom_range(0, COLS + 7));
        r.y        = 8'($urandom_range(0, ROWS + 3));
        r.width    = 8'($urandom_range(0, 24));
        r.height   = 8'($urandom_range(0, 6));
      end else if (kind < 85) begin
        // read inside the store, unused fields random
        r.req_type = REQ_READ;
        r.x        = 8'($urandom_range(0, COLS - 1));
        r.y        = 8'($urandom_range(0, ROWS - 1));
        r.width    = 8'($urandom);
        r.height   = 8'($urandom);
      end else begin
        // anywhere on the 8-bit plane, often off the store
        r.req_type = 1'($urandom);
        r.x        = 8'($urandom);
        r.y        = 8'($urandom);
        r.width    = (r.req_type == REQ_READ) ? 8'($urandom) : 8'($urandom_range(0, 12));
        r.height   = (r.req_type == REQ_READ) ? 8'($urandom) : 8'($urandom_range(0, 4));
      end
      send_word(r, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // wait out every owed result, then a few more cycles for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d fill and %0d read words, %0d results with the clip flag set.",
             fills_sent, reads_sent, clipped_seen);
    $display("Mismatches or stray results: %0d.", errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
